### rtl/bhjt_pkg.sv
// Package for the bucket hash join table: constants, codes, state and command types
`timescale 1ns / 1ps
package bhjt_pkg;

  // table geometry
  localparam int BUCKET_COUNT = 256;
  localparam int BKT_W        = 8;
  localparam int MAX_ROWS     = 1024;
  localparam int ROW_W        = 10;
  localparam int CNT_W        = 11;
  localparam int KEY_W        = 32;
  localparam int TAG_W        = 16;
  localparam int MAX_MATCHES_DEF = 64;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_BUILD  = 2'd2,
    MODE_PROBE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_BUILD = 2'd2,
    ST_TRUNC    = 2'd3
  } status_t;

  // kind of result loaded into the output register
  typedef enum logic [2:0] {
    RES_ACK,
    RES_INS,
    RES_FULL,
    RES_NOBUILD,
    RES_MID,
    RES_FINAL
  } res_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_INS,
    S_INC,
    S_PRE_RD,
    S_PRE_WR,
    S_SC_KEY,
    S_SC_FILL,
    S_SC_WR,
    S_BDONE,
    S_HDR,
    S_HDR_CHK,
    S_WALK_RD,
    S_WALK_CMP,
    S_FIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic      take;
    logic      clr;
    logic      ins_wr;
    logic      cnt_inc;
    logic      idx_clr;
    logic      idx_inc;
    logic      pre_sel;
    logic      pre_wr;
    logic      sc_sel;
    logic      sc_wr;
    logic      set_built;
    logic      pr_start;
    logic      pr_hit;
    logic      pr_adv;
    logic      emit;
    res_kind_t kind;
    logic      trunc;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic built;
    logic idx_pre_last;
    logic rows_zero;
    logic idx_sc_last;
    logic cnt_zero;
    logic hit;
    logic pend_v;
    logic at_max;
    logic rem_last;
    logic uniq;
    logic out_free;
  } sts_t;

endpackage

### rtl/bhjt_ctrl.sv
// Controller state machine for the bucket hash join table
`timescale 1ns / 1ps
module bhjt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_mode,
  output logic          in_ready,
  input  bhjt_pkg::sts_t sts,
  output bhjt_pkg::cmd_t cmd
);
  import bhjt_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (mode_t'(in_mode))
            MODE_CLEAR:  state_nxt = S_CLR;
            MODE_INSERT: state_nxt = S_INS;
            MODE_BUILD:  state_nxt = S_PRE_RD;
            MODE_PROBE:  state_nxt = S_HDR;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLR:    if (sts.out_free) state_nxt = S_IDLE;
      S_INS: begin
        if (!sts.full) state_nxt = S_INC;
        else if (sts.out_free) state_nxt = S_IDLE;
      end
      S_INC:    if (sts.out_free) state_nxt = S_IDLE;
      S_PRE_RD: state_nxt = S_PRE_WR;
      S_PRE_WR: begin
        if (!sts.idx_pre_last) state_nxt = S_PRE_RD;
        else if (sts.rows_zero) state_nxt = S_BDONE;
        else state_nxt = S_SC_KEY;
      end
      S_SC_KEY:  state_nxt = S_SC_FILL;
      S_SC_FILL: state_nxt = S_SC_WR;
      S_SC_WR:   state_nxt = sts.idx_sc_last ? S_BDONE : S_SC_KEY;
      S_BDONE:   if (sts.out_free) state_nxt = S_IDLE;
      S_HDR: begin
        if (sts.built) state_nxt = S_HDR_CHK;
        else if (sts.out_free) state_nxt = S_IDLE;
      end
      S_HDR_CHK: begin
        if (!sts.cnt_zero) state_nxt = S_WALK_RD;
        else if (sts.out_free) state_nxt = S_IDLE;
      end
      S_WALK_RD: state_nxt = S_WALK_CMP;
      S_WALK_CMP: begin
        if (sts.hit && sts.at_max) begin
          if (sts.out_free) state_nxt = S_IDLE;
        end else if (sts.hit) begin
          if (!sts.pend_v || sts.out_free)
            state_nxt = (sts.uniq || sts.rem_last) ? S_FIN : S_WALK_RD;
        end else begin
          state_nxt = sts.rem_last ? S_FIN : S_WALK_RD;
        end
      end
      S_FIN:    if (sts.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    cmd.kind = RES_ACK;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.take    = in_valid;
        cmd.idx_clr = 1'b1;
      end
      S_CLR: begin
        if (sts.out_free) begin
          cmd.clr  = 1'b1;
          cmd.emit = 1'b1;
        end
      end
      S_INS: begin
        if (!sts.full) begin
          cmd.ins_wr = 1'b1;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = RES_FULL;
        end
      end
      S_INC: begin
        if (sts.out_free) begin
          cmd.cnt_inc = 1'b1;
          cmd.emit    = 1'b1;
          cmd.kind    = RES_INS;
        end
      end
      S_PRE_RD: cmd.pre_sel = 1'b1;
      S_PRE_WR: begin
        cmd.pre_sel = 1'b1;
        cmd.pre_wr  = 1'b1;
        cmd.idx_clr = sts.idx_pre_last;
        cmd.idx_inc = !sts.idx_pre_last;
      end
      S_SC_KEY:  cmd = cmd;
      S_SC_FILL: cmd.sc_sel = 1'b1;
      S_SC_WR: begin
        cmd.sc_sel  = 1'b1;
        cmd.sc_wr   = 1'b1;
        cmd.idx_inc = !sts.idx_sc_last;
      end
      S_BDONE: begin
        if (sts.out_free) begin
          cmd.set_built = 1'b1;
          cmd.emit      = 1'b1;
        end
      end
      S_HDR: begin
        if (!sts.built && sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = RES_NOBUILD;
        end
      end
      S_HDR_CHK: begin
        if (!sts.cnt_zero) begin
          cmd.pr_start = 1'b1;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = RES_FINAL;
        end
      end
      S_WALK_RD: cmd = cmd;
      S_WALK_CMP: begin
        if (sts.hit && sts.at_max) begin
          if (sts.out_free) begin
            cmd.emit  = 1'b1;
            cmd.kind  = RES_FINAL;
            cmd.trunc = 1'b1;
          end
        end else if (sts.hit) begin
          if (!sts.pend_v || sts.out_free) begin
            cmd.emit   = sts.pend_v;
            cmd.kind   = RES_MID;
            cmd.pr_hit = 1'b1;
            cmd.pr_adv = !sts.uniq && !sts.rem_last;
          end
        end else begin
          cmd.pr_adv = !sts.rem_last;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = RES_FINAL;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/bhjt_dp.sv
// Datapath of the bucket hash join table: tables, counters, walk registers, output register
`timescale 1ns / 1ps
module bhjt_dp #(
  parameter int MAX_MATCHES = bhjt_pkg::MAX_MATCHES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic signed [bhjt_pkg::KEY_W-1:0] in_key,
  input  logic [bhjt_pkg::TAG_W-1:0] in_probe_tag,
  input  logic                    cfg_we,
  input  logic                    cfg_wdata,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [bhjt_pkg::ROW_W-1:0] out_build_row,
  output logic [bhjt_pkg::TAG_W-1:0] out_tag_out,
  output logic                    out_match,
  output logic [1:0]              out_status,
  output logic                    out_last,
  input  bhjt_pkg::cmd_t          cmd,
  output bhjt_pkg::sts_t          sts
);
  import bhjt_pkg::*;

  localparam int MW = $clog2(MAX_MATCHES + 1);

  // latched transaction and configuration
  logic [KEY_W-1:0] key_r;
  logic [TAG_W-1:0] tag_r;
  logic             uniq_r;

  // memories
  logic [CNT_W-1:0]       cnt_mem  [BUCKET_COUNT];
  logic [BUCKET_COUNT-1:0] cnt_vld_r;
  logic [CNT_W-1:0]       fill_mem [BUCKET_COUNT];
  logic [KEY_W-1:0]       ins_mem  [MAX_ROWS];
  logic [KEY_W+ROW_W-1:0] ord_mem  [MAX_ROWS];

  logic [CNT_W-1:0]       cnt_rd_r;
  logic                   cnt_rv_r;
  logic [CNT_W-1:0]       fill_rd_r;
  logic [KEY_W-1:0]       ins_rd_r;
  logic [KEY_W+ROW_W-1:0] ord_rd_r;

  // counters and walk state
  logic [CNT_W-1:0] row_count_r;
  logic             built_r;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] acc_r;
  logic [ROW_W-1:0] walk_addr_r;
  logic [CNT_W-1:0] rem_r;
  logic [MW-1:0]    nmatch_r;
  logic             pend_v_r;
  logic [ROW_W-1:0] pend_row_r;

  logic             out_valid_r;
  logic [ROW_W-1:0] out_row_r;
  logic [TAG_W-1:0] out_tag_r;
  logic             out_match_r;
  logic [1:0]       out_status_r;
  logic             out_last_r;

  logic [BKT_W-1:0] cnt_raddr;
  logic [BKT_W-1:0] fill_raddr;
  logic [CNT_W-1:0] cnt_val;
  logic [CNT_W-1:0] walk_first;
  logic             out_free;

  assign cnt_raddr  = cmd.pre_sel ? idx_r[BKT_W-1:0] : key_r[BKT_W-1:0];
  assign fill_raddr = cmd.sc_sel ? ins_rd_r[BKT_W-1:0] : key_r[BKT_W-1:0];
  assign cnt_val    = cnt_rv_r ? cnt_rd_r : '0;
  assign walk_first = fill_rd_r - cnt_val - CNT_W'(1);
  assign out_free   = !out_valid_r || out_ready;

  // input and configuration latches
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      key_r <= in_key;
      tag_r <= in_probe_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uniq_r <= 1'b0;
    end else if (cfg_we) begin
      uniq_r <= cfg_wdata;
    end
  end

  // bucket counters, zero until written since the last clear
  always_ff @(posedge clk) begin
    cnt_rd_r <= cnt_mem[cnt_raddr];
    if (cmd.cnt_inc) begin
      cnt_mem[key_r[BKT_W-1:0]] <= cnt_val + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
      cnt_rv_r  <= 1'b0;
    end else begin
      cnt_rv_r <= cnt_vld_r[cnt_raddr];
      if (cmd.clr) begin
        cnt_vld_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_vld_r[key_r[BKT_W-1:0]] <= 1'b1;
      end
    end
  end

  // fill pointers: bucket start after prefix, bucket end after scatter
  always_ff @(posedge clk) begin
    fill_rd_r <= fill_mem[fill_raddr];
    if (cmd.pre_wr) begin
      fill_mem[idx_r[BKT_W-1:0]] <= acc_r;
    end else if (cmd.sc_wr) begin
      fill_mem[ins_rd_r[BKT_W-1:0]] <= fill_rd_r + CNT_W'(1);
    end
  end

  // keys in arrival order
  always_ff @(posedge clk) begin
    ins_rd_r <= ins_mem[idx_r[ROW_W-1:0]];
    if (cmd.ins_wr) begin
      ins_mem[row_count_r[ROW_W-1:0]] <= key_r;
    end
  end

  // keys and row numbers in bucket order
  always_ff @(posedge clk) begin
    ord_rd_r <= ord_mem[walk_addr_r];
    if (cmd.sc_wr) begin
      ord_mem[ROW_W'(fill_rd_r - CNT_W'(1))] <= {ins_rd_r, idx_r[ROW_W-1:0]};
    end
  end

  // row count, built flag, build sweep counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= '0;
      built_r     <= 1'b0;
    end else begin
      if (cmd.clr) begin
        row_count_r <= '0;
        built_r     <= 1'b0;
      end else if (cmd.cnt_inc) begin
        row_count_r <= row_count_r + CNT_W'(1);
        built_r     <= 1'b0;
      end else if (cmd.set_built) begin
        built_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      acc_r <= CNT_W'(1);
    end else begin
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (cmd.take) begin
        acc_r <= CNT_W'(1);
      end else if (cmd.pre_wr) begin
        acc_r <= acc_r + cnt_val;
      end
    end
  end

  // probe walk; no match is pending at the start of a transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      nmatch_r <= '0;
    end else if (cmd.take || cmd.pr_start) begin
      pend_v_r <= 1'b0;
      nmatch_r <= '0;
    end else if (cmd.pr_hit) begin
      pend_v_r <= 1'b1;
      nmatch_r <= nmatch_r + MW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pr_start) begin
      walk_addr_r <= walk_first[ROW_W-1:0];
      rem_r       <= cnt_val;
    end else if (cmd.pr_adv) begin
      walk_addr_r <= walk_addr_r + ROW_W'(1);
      rem_r       <= rem_r - CNT_W'(1);
    end
    if (cmd.pr_hit) begin
      pend_row_r <= ord_rd_r[ROW_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row_r    <= '0;
      out_tag_r    <= tag_r;
      out_match_r  <= 1'b0;
      out_status_r <= ST_OK;
      out_last_r   <= 1'b1;
      case (cmd.kind)
        RES_ACK:     out_row_r <= '0;
        RES_INS:     out_row_r <= row_count_r[ROW_W-1:0];
        RES_FULL:    out_status_r <= ST_FULL;
        RES_NOBUILD: out_status_r <= ST_NO_BUILD;
        RES_MID: begin
          out_row_r   <= pend_row_r;
          out_match_r <= 1'b1;
          out_last_r  <= 1'b0;
        end
        RES_FINAL: begin
          if (pend_v_r) begin
            out_row_r    <= pend_row_r;
            out_match_r  <= 1'b1;
            out_status_r <= cmd.trunc ? ST_TRUNC : ST_OK;
          end
        end
        default: out_row_r <= '0;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_build_row = out_row_r;
  assign out_tag_out   = out_tag_r;
  assign out_match     = out_match_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

  // status to the controller
  always_comb begin
    sts              = '0;
    sts.full         = row_count_r >= CNT_W'(MAX_ROWS);
    sts.built        = built_r;
    sts.idx_pre_last = idx_r == CNT_W'(BUCKET_COUNT - 1);
    sts.rows_zero    = row_count_r == '0;
    sts.idx_sc_last  = idx_r == (row_count_r - CNT_W'(1));
    sts.cnt_zero     = cnt_val == '0;
    sts.hit          = ord_rd_r[KEY_W+ROW_W-1:ROW_W] == key_r;
    sts.pend_v       = pend_v_r;
    sts.at_max       = nmatch_r == MW'(MAX_MATCHES);
    sts.rem_last     = rem_r == CNT_W'(1);
    sts.uniq         = uniq_r;
    sts.out_free     = out_free;
  end

endmodule

### rtl/bucket_hash_join_table.sv
// Top level of the bucket hash join table
`timescale 1ns / 1ps
// Bucket hash join table. One transaction at a time is accepted; in_ready is high only
// while the controller is idle. A result waits in an output register, and the walk stalls
// while that register is full. A clear loads its result; an insert stores the key, then
// loads its row number or a full status; a build runs a prefix pass over the bucket
// counter memory, then a scatter pass that reads each inserted row's key and its bucket's
// fill pointer and writes the row to the ordered-key memory; a probe before build or to
// an empty bucket loads its result directly, otherwise the bucket's entries are walked
// (one ordered-key memory read and one compare per entry; the walk ends at the bucket's
// last entry or, in unique mode, at the first match, and a walk cut off at the match
// limit loads its closing result at the compare). A full output register stalls each
// load. Keys are bucketed by their low 8 bits. The bucket counters are cleared at once
// by per-bucket valid bits; no clearing pass is needed.
module bucket_hash_join_table #(
  parameter int MAX_MATCHES = bhjt_pkg::MAX_MATCHES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_mode,
  input  logic signed [bhjt_pkg::KEY_W-1:0] in_key,
  input  logic [bhjt_pkg::TAG_W-1:0] in_probe_tag,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [bhjt_pkg::ROW_W-1:0] out_build_row,
  output logic [bhjt_pkg::TAG_W-1:0] out_tag_out,
  output logic                    out_match,
  output logic [1:0]              out_status,
  output logic                    out_last,
  input  logic                    cfg_we,
  input  logic                    cfg_wdata
);
  import bhjt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  bhjt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // tables and result register
  bhjt_dp #(
    .MAX_MATCHES (MAX_MATCHES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_key        (in_key),
    .in_probe_tag  (in_probe_tag),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_build_row (out_build_row),
    .out_tag_out   (out_tag_out),
    .out_match     (out_match),
    .out_status    (out_status),
    .out_last      (out_last),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

### rtl/bhjt_checker.sv
// Port-level assertions for the bucket hash join table, bound to the top level
`timescale 1ns / 1ps
module bhjt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [9:0]  out_build_row,
  input logic [15:0] out_tag_out,
  input logic        out_match,
  input logic [1:0]  out_status,
  input logic        out_last
);
  import bhjt_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_build_row)
      && $stable(out_tag_out) && $stable(out_match) && $stable(out_status)
      && $stable(out_last))
    else $error("stalled result changed");

  // one transaction in flight: ready drops after acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted while busy");

  // a non-match result always closes its transaction
  a_nomatch_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_match |-> out_last)
    else $error("non-match result not last");

  // full and probe-before-build results carry no match and no row
  a_err_plain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_NO_BUILD)
      |-> !out_match && out_build_row == '0)
    else $error("error result carries a match");

  // truncation is flagged only on a final match
  a_trunc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_TRUNC |-> out_match && out_last)
    else $error("bad truncation result");

endmodule

bind bucket_hash_join_table bhjt_checker u_bhjt_checker (.*);
